@@ rtl/core/mcfe_pkg.sv @@
// ----------------------------------------------------------------------------
// mcfe_pkg
// Types and constants shared by the motor command frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mcfe_pkg;

  typedef enum logic [1:0] {
    KIND_MOVE    = 2'd0,
    KIND_ENABLE  = 2'd1,
    KIND_DISABLE = 2'd2,
    KIND_ZERO    = 2'd3
  } mcfe_kind_t;

  typedef enum logic [2:0] {
    REG_POS_LIMIT = 3'd0,
    REG_VEL_LIMIT = 3'd1,
    REG_TRQ_LIMIT = 3'd2,
    REG_KP_MAX    = 3'd3,
    REG_KD_MAX    = 3'd4,
    REG_AXIS_REV  = 3'd5
  } mcfe_reg_t;

  localparam int unsigned VAL_W  = 27;  // command value width
  localparam int unsigned LIM_W  = 26;  // limit register width
  localparam int unsigned CODE_W = 16;  // widest code
  localparam int unsigned QBITS  = 16;  // quotient bits per division
  localparam int unsigned LAT    = 3 + QBITS;  // lane latency

  localparam logic [CODE_W-1:0] CODE12_MAX = 16'h0FFF;
  localparam logic [CODE_W-1:0] CODE16_MAX = 16'hFFFF;

  localparam logic [63:0] FRAME_ENABLE  = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam logic [63:0] FRAME_DISABLE = 64'hFFFF_FFFF_FFFF_FFFD;
  localparam logic [63:0] FRAME_ZERO    = 64'hFFFF_FFFF_FFFF_FFFE;

  localparam logic [LIM_W-1:0] RST_POS_LIMIT = 26'd819200;
  localparam logic [LIM_W-1:0] RST_VEL_LIMIT = 26'd1474560;
  localparam logic [LIM_W-1:0] RST_TRQ_LIMIT = 26'd786432;
  localparam logic [LIM_W-1:0] RST_KP_MAX    = 26'd32768000;
  localparam logic [LIM_W-1:0] RST_KD_MAX    = 26'd327680;

  // per-lane setup: bound, gain style (0..max) or symmetric, negate, code range
  typedef struct packed {
    logic [LIM_W-1:0]  lim;
    logic              gain;
    logic              neg;
    logic [CODE_W-1:0] codemax;
  } mcfe_lane_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/mcfe_if.sv @@
// ----------------------------------------------------------------------------
// mcfe_if
// Handshake channels of the motor command frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcfe_cmd_if;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic signed [26:0]  target_position;
  logic signed [26:0]  target_velocity;
  logic signed [26:0]  stiffness;
  logic signed [26:0]  damping;
  logic signed [26:0]  feed_torque;
  modport source (output valid, kind, target_position, target_velocity, stiffness,
                  damping, feed_torque, input ready);
  modport sink   (input valid, kind, target_position, target_velocity, stiffness,
                  damping, feed_torque, output ready);
endinterface

interface mcfe_frame_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_data;
  modport source (output valid, frame_data, input ready);
  modport sink   (input valid, frame_data, output ready);
endinterface

interface mcfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [25:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mcfe_lane.sv @@
// ----------------------------------------------------------------------------
// mcfe_lane
// One value: clamp, offset, scale and a pipelined restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfe_lane (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [26:0]             x,
  input  wire mcfe_pkg::mcfe_lane_cfg_t       cfg,
  output logic [mcfe_pkg::CODE_W-1:0]         code
);
  import mcfe_pkg::*;

  logic signed [27:0] xs, ls, lo, xc, av;
  logic [26:0]        dv;
  logic [27:0]        a_r;
  logic               z1_r, z2_r;
  logic [43:0]        n_r;
  logic [27:0]        r_r  [0:QBITS];
  logic [15:0]        lo_r [0:QBITS];
  logic [15:0]        q_r  [0:QBITS];
  logic               z_r  [0:QBITS];
  logic [27:0]        t    [0:QBITS-1];
  logic               ge   [0:QBITS-1];

  always_comb begin
    xs = {x[26], x};
    ls = {2'b00, cfg.lim};
    lo = cfg.gain ? 28'sd0 : -ls;
    if (xs < lo) begin
      xc = lo;
    end else if (xs > ls) begin
      xc = ls;
    end else begin
      xc = xs;
    end
    if (cfg.gain) begin
      av = xc;
    end else if (cfg.neg) begin
      av = ls - xc;
    end else begin
      av = xc + ls;
    end
    // divisor: max for gains, twice the bound otherwise
    dv = cfg.gain ? {1'b0, cfg.lim} : {cfg.lim, 1'b0};
  end

  always_comb begin
    for (int i = 0; i < QBITS; i++) begin
      t[i]  = {r_r[i][26:0], lo_r[i][15]};
      ge[i] = (t[i] >= {1'b0, dv});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= av;
      z1_r <= (cfg.lim == '0);
      n_r  <= {16'b0, a_r} * {28'b0, cfg.codemax};
      z2_r <= z1_r;
      // n < d * 2^16, so the top part already sits below the divisor
      r_r[0]  <= n_r[43:16];
      lo_r[0] <= n_r[15:0];
      q_r[0]  <= '0;
      z_r[0]  <= z2_r;
      for (int i = 0; i < QBITS; i++) begin
        r_r[i+1]  <= ge[i] ? (t[i] - {1'b0, dv}) : t[i];
        lo_r[i+1] <= {lo_r[i][14:0], 1'b0};
        q_r[i+1]  <= {q_r[i][14:0], ge[i]};
        z_r[i+1]  <= z_r[i];
      end
    end
  end

  assign code = z_r[QBITS] ? '0 : q_r[QBITS];

endmodule

`default_nettype wire

@@ rtl/core/motor_command_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// motor_command_frame_encoder
// Packs a motor command into an eight-byte frame, or emits a fixed frame.
// ----------------------------------------------------------------------------
//  port     | dir | content
//  in_cmd   | in  | kind, position, velocity, kp, kd, torque
//  out_frm  | out | frame_data, 64 bit, byte 0 in bits 63..56
//  cfg_wr   | in  | register index and data, always ready
//
//  One item per cycle unless the output stalls. Stages: clamp, multiply,
//  divider load, 16 divide steps, frame register. Five lanes run side by side, one per value.
//  Synchronous active-low reset clears the valid bits and loads the register defaults.
//  A stalled output holds the whole pipeline; in_cmd.ready follows that.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_command_frame_encoder (
  input  wire logic clk,
  input  wire logic rst_n,
  mcfe_cmd_if.sink      in_cmd,
  mcfe_frame_if.source  out_frm,
  mcfe_cfg_if.sink      cfg_wr
);
  import mcfe_pkg::*;

  logic [LIM_W-1:0] pos_lim_r, vel_lim_r, trq_lim_r, kp_max_r, kd_max_r;
  logic             axis_rev_r;
  logic             en;
  logic             vld_r  [0:LAT-1];
  mcfe_kind_t       kind_r [0:LAT-1];
  logic             out_valid_r;
  logic [63:0]      frame_r;
  logic [63:0]      frame_nxt;
  mcfe_lane_cfg_t   pc, vc, tc, kpc, kdc;
  logic [CODE_W-1:0] cp, cv, ct, ckp, ckd;

  assign en           = !out_valid_r || out_frm.ready;
  assign in_cmd.ready = en;
  assign cfg_wr.ready = 1'b1;
  assign out_frm.valid      = out_valid_r;
  assign out_frm.frame_data = frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_lim_r  <= RST_POS_LIMIT;
      vel_lim_r  <= RST_VEL_LIMIT;
      trq_lim_r  <= RST_TRQ_LIMIT;
      kp_max_r   <= RST_KP_MAX;
      kd_max_r   <= RST_KD_MAX;
      axis_rev_r <= 1'b1;
    end else if (cfg_wr.valid) begin
      case (mcfe_reg_t'(cfg_wr.index))
        REG_POS_LIMIT: pos_lim_r  <= cfg_wr.data;
        REG_VEL_LIMIT: vel_lim_r  <= cfg_wr.data;
        REG_TRQ_LIMIT: trq_lim_r  <= cfg_wr.data;
        REG_KP_MAX:    kp_max_r   <= cfg_wr.data;
        REG_KD_MAX:    kd_max_r   <= cfg_wr.data;
        REG_AXIS_REV:  axis_rev_r <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  assign pc  = '{lim: pos_lim_r, gain: 1'b0, neg: axis_rev_r, codemax: CODE16_MAX};
  assign vc  = '{lim: vel_lim_r, gain: 1'b0, neg: axis_rev_r, codemax: CODE12_MAX};
  assign tc  = '{lim: trq_lim_r, gain: 1'b0, neg: axis_rev_r, codemax: CODE12_MAX};
  assign kpc = '{lim: kp_max_r,  gain: 1'b1, neg: 1'b0,       codemax: CODE12_MAX};
  assign kdc = '{lim: kd_max_r,  gain: 1'b1, neg: 1'b0,       codemax: CODE12_MAX};

  mcfe_lane u_pos (.clk(clk), .en(en), .x(in_cmd.target_position), .cfg(pc),  .code(cp));
  mcfe_lane u_vel (.clk(clk), .en(en), .x(in_cmd.target_velocity), .cfg(vc),  .code(cv));
  mcfe_lane u_trq (.clk(clk), .en(en), .x(in_cmd.feed_torque),     .cfg(tc),  .code(ct));
  mcfe_lane u_kp  (.clk(clk), .en(en), .x(in_cmd.stiffness),       .cfg(kpc), .code(ckp));
  mcfe_lane u_kd  (.clk(clk), .en(en), .x(in_cmd.damping),         .cfg(kdc), .code(ckd));

  // merge: pack the lane codes or pick a fixed frame
  always_comb begin
    case (kind_r[LAT-1])
      KIND_ENABLE:  frame_nxt = FRAME_ENABLE;
      KIND_DISABLE: frame_nxt = FRAME_DISABLE;
      KIND_ZERO:    frame_nxt = FRAME_ZERO;
      default:      frame_nxt = {cp, cv[11:0], ckp[11:0], ckd[11:0], ct[11:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0]    <= in_cmd.valid;
      out_valid_r <= vld_r[LAT-1];
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r[0] <= mcfe_kind_t'(in_cmd.kind);
      frame_r   <= frame_nxt;
      for (int i = 1; i < LAT; i++) begin
        kind_r[i] <= kind_r[i-1];
      end
    end
  end

  a_pipe_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[LAT-1]) |=> out_valid_r)
    else $error("item lost between lanes and frame register");

  a_lin_codes: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] |-> (cv[15:12] == 4'd0 && ct[15:12] == 4'd0))
    else $error("12-bit lane code out of range");

  a_gain_codes: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] |-> (ckp[15:12] == 4'd0 && ckd[15:12] == 4'd0))
    else $error("gain code out of range");

endmodule

`default_nettype wire

@@ verif/motor_command_frame_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// motor_command_frame_encoder_tb
// Self-checking bench for the motor command frame encoder: directed and random
// commands under several register settings, random stalls on both channels,
// every frame compared in order against a bit-accurate predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module motor_command_frame_encoder_tb;
  import mcfe_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [26:0] pos;
    logic signed [26:0] vel;
    logic signed [26:0] kp;
    logic signed [26:0] kd;
    logic signed [26:0] trq;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mcfe_cmd_if   cmd_ch();
  mcfe_frame_if frm_ch();
  mcfe_cfg_if   cfg_ch();

  motor_command_frame_encoder dut (
    .clk(clk), .rst_n(rst_n), .in_cmd(cmd_ch), .out_frm(frm_ch), .cfg_wr(cfg_ch)
  );

  // predictor copy of the registers
  logic [25:0] lim_pos, lim_vel, lim_trq, max_kp, max_kd;
  logic        rev_axis;

  cmd_t        cmd_q[$];
  logic [63:0] frame_q[$];
  int          n_err = 0;
  bit          hold_tx = 1'b0;
  int          tx_gap = 0;
  int          rx_gap = 0;

  initial forever #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] sym_code(logic signed [26:0] x, logic [25:0] lim,
                                           logic neg, logic [15:0] cmax);
    longint l, v;
    l = lim;
    v = x;
    if (l == 0) return '0;
    if (v < -l) v = -l;
    if (v > l) v = l;
    if (neg) v = -v;
    return ((v + l) * longint'(cmax)) / (2 * l);
  endfunction

  function automatic logic [63:0] gain_code(logic signed [26:0] x, logic [25:0] mx);
    longint m, v;
    m = mx;
    v = x;
    if (m == 0) return '0;
    if (v < 0) v = 0;
    if (v > m) v = m;
    return (v * 4095) / m;
  endfunction

  function automatic logic [63:0] encode_frame(cmd_t c);
    logic [63:0] f;
    case (mcfe_kind_t'(c.kind))
      KIND_ENABLE:  return FRAME_ENABLE;
      KIND_DISABLE: return FRAME_DISABLE;
      KIND_ZERO:    return FRAME_ZERO;
      default: begin
        f = sym_code(c.pos, lim_pos, rev_axis, CODE16_MAX) << 48;
        f |= (sym_code(c.vel, lim_vel, rev_axis, CODE12_MAX) & 64'hFFF) << 36;
        f |= (gain_code(c.kp, max_kp) & 64'hFFF) << 24;
        f |= (gain_code(c.kd, max_kd) & 64'hFFF) << 12;
        f |= sym_code(c.trq, lim_trq, rev_axis, CODE12_MAX) & 64'hFFF;
        return f;
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        frame_q.push_back(encode_frame(cmd_t'({cmd_ch.kind, cmd_ch.target_position,
          cmd_ch.target_velocity, cmd_ch.stiffness, cmd_ch.damping, cmd_ch.feed_torque})));
        tx_gap = gap_len();
      end
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_q.size() > 0 && !hold_tx) begin
          cmd_t c;
          c = cmd_q.pop_front();
          cmd_ch.valid           <= 1'b1;
          cmd_ch.kind            <= c.kind;
          cmd_ch.target_position <= c.pos;
          cmd_ch.target_velocity <= c.vel;
          cmd_ch.stiffness       <= c.kp;
          cmd_ch.damping         <= c.kd;
          cmd_ch.feed_torque     <= c.trq;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      frm_ch.ready <= 1'b0;
    end else begin
      if (frm_ch.valid && frm_ch.ready) begin
        if (frame_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected frame %h", frm_ch.frame_data);
        end else begin
          logic [63:0] exp_f;
          exp_f = frame_q.pop_front();
          if (exp_f !== frm_ch.frame_data) begin
            n_err++;
            if (n_err <= 10)
              $display("frame error: expected %h actual %h", exp_f, frm_ch.frame_data);
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        frm_ch.ready <= 1'b0;
      end else begin
        frm_ch.ready <= 1'b1;
        rx_gap = gap_len();
      end
    end
  end

  task automatic wait_drained();
    while (cmd_q.size() > 0 || cmd_ch.valid || frame_q.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(mcfe_reg_t idx, logic [25:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_POS_LIMIT: lim_pos = val;
      REG_VEL_LIMIT: lim_vel = val;
      REG_TRQ_LIMIT: lim_trq = val;
      REG_KP_MAX:    max_kp = val;
      REG_KD_MAX:    max_kd = val;
      default:       rev_axis = val[0];
    endcase
  endtask

  function automatic logic signed [26:0] rnd_val(logic [25:0] lim);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 27'($urandom);                  // anything, full width
    if (r == 2) return $urandom_range(0, 1) ? 27'sh3FFFFFF : -27'sh4000000;
    if (r == 3) return $urandom_range(0, 1) ? $signed({1'b0, lim}) : -$signed({1'b0, lim});
    if (lim == 0) return 27'($urandom_range(0, 3));
    return 27'($signed({1'b0, 26'($urandom_range(0, lim))})
               - (r[0] ? 0 : $signed({1'b0, lim})));
  endfunction

  task automatic push_random(int n);
    cmd_t c;
    repeat (n) begin
      c.kind = ($urandom_range(0, 9) < 7) ? KIND_MOVE : 2'($urandom_range(1, 3));
      c.pos = rnd_val(lim_pos);
      c.vel = rnd_val(lim_vel);
      c.kp  = rnd_val(max_kp);
      c.kd  = rnd_val(max_kd);
      c.trq = rnd_val(lim_trq);
      cmd_q.push_back(c);
    end
  endtask

  task automatic push_cmd(mcfe_kind_t k, logic signed [26:0] v);
    cmd_q.push_back('{k, v, v, v, v, v});
  endtask

  initial begin
    cmd_ch.valid = 1'b0; cmd_ch.kind = '0; cmd_ch.target_position = '0;
    cmd_ch.target_velocity = '0; cmd_ch.stiffness = '0; cmd_ch.damping = '0;
    cmd_ch.feed_torque = '0;
    frm_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    lim_pos = RST_POS_LIMIT; lim_vel = RST_VEL_LIMIT; lim_trq = RST_TRQ_LIMIT;
    max_kp = RST_KP_MAX; max_kd = RST_KD_MAX; rev_axis = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and fixed frames at reset settings
    push_cmd(KIND_MOVE, 27'sh3FFFFFF);
    push_cmd(KIND_MOVE, -27'sh4000000);
    push_cmd(KIND_MOVE, 27'sd0);
    push_cmd(KIND_MOVE, -27'sd1);
    push_cmd(KIND_MOVE, 27'sd819200);
    push_cmd(KIND_MOVE, -27'sd786432);
    push_cmd(KIND_ENABLE, 27'sd5);
    push_cmd(KIND_DISABLE, -27'sd5);
    push_cmd(KIND_ZERO, 27'sh3FFFFFF);
    cmd_q.push_back('{KIND_MOVE, 27'sd12345, -27'sd999, 27'sd327680, 27'sd32768000, 27'sd1});
    push_random(40);
    wait_drained();

    // zero limits (no division), no reversal
    repeat (LAT + 4) @(posedge clk);
    write_reg(REG_POS_LIMIT, 26'd0); write_reg(REG_VEL_LIMIT, 26'd0);
    write_reg(REG_TRQ_LIMIT, 26'd0); write_reg(REG_KP_MAX, 26'd0);
    write_reg(REG_KD_MAX, 26'd0); write_reg(REG_AXIS_REV, 26'd0);
    push_cmd(KIND_MOVE, 27'sh3FFFFFF);
    push_cmd(KIND_MOVE, -27'sh4000000);
    push_random(30);
    wait_drained();

    // largest limits, and smallest
    repeat (LAT + 4) @(posedge clk);
    write_reg(REG_POS_LIMIT, 26'h3FFFFFF); write_reg(REG_VEL_LIMIT, 26'h3FFFFFF);
    write_reg(REG_TRQ_LIMIT, 26'h3FFFFFF); write_reg(REG_KP_MAX, 26'h3FFFFFF);
    write_reg(REG_KD_MAX, 26'd1); write_reg(REG_AXIS_REV, 26'd1);
    push_cmd(KIND_MOVE, 27'sh3FFFFFF);
    push_cmd(KIND_MOVE, -27'sh4000000);
    push_random(120);
    // let a batch get in flight, then hold the sender until the pipe has emptied
    repeat (60) @(posedge clk);
    hold_tx = 1'b1;
    while (frame_q.size() > 0 || cmd_ch.valid) @(posedge clk);
    hold_tx = 1'b0;
    push_random(80);
    wait_drained();

    repeat (4) begin
      repeat (LAT + 4) @(posedge clk);
      write_reg(REG_POS_LIMIT, $urandom_range(0, 1) ? 26'd1 : 26'($urandom));
      write_reg(REG_VEL_LIMIT, 26'($urandom_range(1, 3000000)));
      write_reg(REG_TRQ_LIMIT, 26'($urandom));
      write_reg(REG_KP_MAX, 26'($urandom_range(1, 40000000)));
      write_reg(REG_KD_MAX, 26'($urandom));
      write_reg(REG_AXIS_REV, 26'($urandom_range(0, 1)));
      push_random(95);
      wait_drained();
    end

    repeat (LAT + 10) @(posedge clk);
    if (n_err == 0) begin
      $display("motor_command_frame_encoder: match");
    end else begin
      $display("motor_command_frame_encoder: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("motor_command_frame_encoder: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mcfe_pkg.sv
rtl/core/mcfe_if.sv
rtl/core/mcfe_lane.sv
rtl/core/motor_command_frame_encoder.sv
verif/motor_command_frame_encoder_tb.sv
